// ----- src/ecal_pkg.sv -----
// ----------------------------------------------------------------------------
// ecal_pkg
// Shared types, constants and the month-length table for the epoch-seconds
// to calendar date converter.
// ----------------------------------------------------------------------------
package ecal_pkg;

	localparam int unsigned InWidth   = 31;
	localparam int unsigned TimeWidth = 32;
	localparam int unsigned DaysWidth = 16;

	localparam logic [TimeWidth-1:0] ZoneOffset = 32'd28800;
	localparam logic [16:0]          SecPerDay  = 17'd86400;
	localparam logic [11:0]          SecPerHour = 12'd3600;
	localparam logic [5:0]           SecPerMin  = 6'd60;

	// days = ((t >> 7) * DayRecip) >> 35, exact for any 25-bit t >> 7 (86400 = 128 * 675)
	localparam logic [25:0] DayRecip  = 26'd50903317;
	// hour = ((s >> 4) * HourRecip) >> 21, exact for any second of day
	localparam logic [13:0] HourRecip = 14'd9321;
	// minute = ((s >> 2) * MinRecip) >> 14, exact for any second of hour
	localparam logic [10:0] MinRecip  = 11'd1093;

	localparam logic [10:0] EpochYear    = 11'd1970;
	localparam logic [1:0]  EpochMod4    = 2'd2;
	localparam logic [6:0]  EpochMod100  = 7'd70;
	localparam logic [8:0]  EpochMod400  = 9'd370;
	localparam logic [6:0]  Mod100Last   = 7'd99;
	localparam logic [8:0]  Mod400Last   = 9'd399;
	localparam logic [8:0]  YearLenLeap  = 9'd366;
	localparam logic [8:0]  YearLenPlain = 9'd365;

	localparam logic [3:0] MonJan = 4'd0;
	localparam logic [3:0] MonFeb = 4'd1;
	localparam logic [3:0] MonMar = 4'd2;
	localparam logic [3:0] MonApr = 4'd3;
	localparam logic [3:0] MonMay = 4'd4;
	localparam logic [3:0] MonJun = 4'd5;
	localparam logic [3:0] MonJul = 4'd6;
	localparam logic [3:0] MonAug = 4'd7;
	localparam logic [3:0] MonSep = 4'd8;
	localparam logic [3:0] MonOct = 4'd9;
	localparam logic [3:0] MonNov = 4'd10;
	localparam logic [3:0] MonDec = 4'd11;

	typedef struct packed {
		logic [InWidth-1:0] epoch_seconds;
	} ecal_in_t;

	typedef struct packed {
		logic [10:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} ecal_out_t;

	typedef struct packed {
		logic load_time;
		logic split_day;
		logic split_sod;
		logic split_hour;
		logic split_soh;
		logic split_min;
		logic split_sec;
		logic cal_load;
		logic year_step;
		logic month_step;
		logic out_load;
	} ecal_cmd_t;

	typedef struct packed {
		logic year_fits;
		logic month_last;
	} ecal_sts_t;

	function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
		logic [4:0] len;
		case (mon)
			MonJan, MonMar, MonMay, MonJul, MonAug, MonOct, MonDec: len = 5'd31;
			MonApr, MonJun, MonSep, MonNov: len = 5'd30;
			MonFeb: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

// ----- src/ecal_in_if.sv -----
// ----------------------------------------------------------------------------
// ecal_in_if
// Valid/ready channel carrying one epoch-seconds beat.
// ----------------------------------------------------------------------------
interface ecal_in_if;
	import ecal_pkg::*;

	logic     valid;
	logic     ready;
	ecal_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ----- src/ecal_out_if.sv -----
// ----------------------------------------------------------------------------
// ecal_out_if
// Valid/ready channel carrying one calendar date and time beat.
// ----------------------------------------------------------------------------
interface ecal_out_if;
	import ecal_pkg::*;

	logic      valid;
	logic      ready;
	ecal_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// ----- src/ecal_dp.sv -----
// ----------------------------------------------------------------------------
// ecal_dp
// Datapath: reciprocal-multiply splits of the zoned time into days, hour,
// minute and second, a year walker with running mod 4/100/400 counters, a
// month walker and the output holding register.
// ----------------------------------------------------------------------------
module ecal_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  ecal_pkg::ecal_in_t  epoch_data,
	input  ecal_pkg::ecal_cmd_t cmd,
	output ecal_pkg::ecal_sts_t sts,
	output ecal_pkg::ecal_out_t date_data
);
	import ecal_pkg::*;

	logic [TimeWidth-1:0] time_q;
	logic [DaysWidth-1:0] day_num_q;
	logic [16:0]          sod_q;
	logic [4:0]           hour_q;
	logic [11:0]          soh_q;
	logic [5:0]           minute_q;
	logic [5:0]           second_q;
	logic [DaysWidth-1:0] days_q;
	logic [10:0]          year_q;
	logic [1:0]           mod4_q;
	logic [6:0]           mod100_q;
	logic [8:0]           mod400_q;
	logic [3:0]           month_q;
	ecal_out_t            result_q;

	logic [50:0] day_prod;
	logic [25:0] hour_prod;
	logic [19:0] min_prod;
	logic        leap;
	logic [8:0]  year_len;
	logic [4:0]  mon_len;

	assign day_prod  = time_q[TimeWidth-1:7] * DayRecip;
	assign hour_prod = 26'(sod_q[16:4] * HourRecip);
	assign min_prod  = 20'(soh_q[11:2] * MinRecip);

	assign leap     = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
	assign year_len = leap ? YearLenLeap : YearLenPlain;
	assign mon_len  = month_len(month_q, leap);

	assign sts.year_fits  = days_q < {{(DaysWidth-9){1'b0}}, year_len};
	assign sts.month_last = (month_q == MonDec) ||
		(days_q < {{(DaysWidth-5){1'b0}}, mon_len});

	// time split, one multiply per step; remainders fit the low bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			day_num_q <= '0;
			sod_q     <= '0;
			hour_q    <= '0;
			soh_q     <= '0;
			minute_q  <= '0;
			second_q  <= '0;
		end else begin
			if (cmd.load_time)
				time_q <= {1'b0, epoch_data.epoch_seconds} + ZoneOffset;
			if (cmd.split_day)
				day_num_q <= day_prod[50:35];
			if (cmd.split_sod)
				sod_q <= time_q[16:0] - 17'(day_num_q * SecPerDay);
			if (cmd.split_hour)
				hour_q <= hour_prod[25:21];
			if (cmd.split_soh)
				soh_q <= sod_q[11:0] - 12'(hour_q * SecPerHour);
			if (cmd.split_min)
				minute_q <= min_prod[19:14];
			if (cmd.split_sec)
				second_q <= soh_q[5:0] - 6'(minute_q * SecPerMin);
		end
	end

	// calendar walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			days_q   <= '0;
			year_q   <= EpochYear;
			mod4_q   <= EpochMod4;
			mod100_q <= EpochMod100;
			mod400_q <= EpochMod400;
			month_q  <= MonJan;
		end else if (cmd.cal_load) begin
			days_q   <= day_num_q;
			year_q   <= EpochYear;
			mod4_q   <= EpochMod4;
			mod100_q <= EpochMod100;
			mod400_q <= EpochMod400;
			month_q  <= MonJan;
		end else if (cmd.year_step) begin
			days_q   <= days_q - {{(DaysWidth-9){1'b0}}, year_len};
			year_q   <= year_q + 11'd1;
			mod4_q   <= mod4_q + 2'd1;
			mod100_q <= (mod100_q == Mod100Last) ? 7'd0 : mod100_q + 7'd1;
			mod400_q <= (mod400_q == Mod400Last) ? 9'd0 : mod400_q + 9'd1;
		end else if (cmd.month_step) begin
			days_q  <= days_q - {{(DaysWidth-5){1'b0}}, mon_len};
			month_q <= month_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q <= '0;
		end else if (cmd.out_load) begin
			result_q.year   <= year_q;
			result_q.month  <= month_q + 4'd1;
			result_q.day    <= days_q[4:0] + 5'd1;
			result_q.hour   <= hour_q;
			result_q.minute <= minute_q;
			result_q.second <= second_q;
		end
	end

	assign date_data = result_q;

endmodule

// ----- src/ecal_ctrl.sv -----
// ----------------------------------------------------------------------------
// ecal_ctrl
// Controller: sequences the time-of-day split steps, runs the year and month
// walk alongside the hour/minute split, and owns the output valid flag.
// ----------------------------------------------------------------------------
module ecal_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                epoch_valid,
	output logic                epoch_ready,
	output logic                date_valid,
	input  logic                date_ready,
	output ecal_pkg::ecal_cmd_t cmd,
	input  ecal_pkg::ecal_sts_t sts
);
	import ecal_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b00000001,
		ST_DAY  = 8'b00000010,
		ST_SOD  = 8'b00000100,
		ST_HOUR = 8'b00001000,
		ST_SOH  = 8'b00010000,
		ST_MIN  = 8'b00100000,
		ST_SEC  = 8'b01000000,
		ST_FIN  = 8'b10000000
	} state_t;

	typedef enum logic [3:0] {
		CAL_IDLE  = 4'b0001,
		CAL_YEAR  = 4'b0010,
		CAL_MONTH = 4'b0100,
		CAL_DONE  = 4'b1000
	} cal_state_t;

	state_t     state_q, state_d;
	cal_state_t cal_q, cal_d;
	logic       valid_q;
	logic       accept;
	logic       out_free;

	assign epoch_ready = state_q == ST_IDLE;
	assign accept      = epoch_valid && epoch_ready;
	assign out_free    = !valid_q || date_ready;
	assign date_valid  = valid_q;

	always_comb begin
		state_d = state_q;
		cal_d   = cal_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_time = 1'b1;
					state_d       = ST_DAY;
				end
			end
			ST_DAY: begin
				cmd.split_day = 1'b1;
				state_d       = ST_SOD;
			end
			ST_SOD: begin
				cmd.split_sod = 1'b1;
				cmd.cal_load  = 1'b1;
				cal_d         = CAL_YEAR;
				state_d       = ST_HOUR;
			end
			ST_HOUR: begin
				cmd.split_hour = 1'b1;
				state_d        = ST_SOH;
			end
			ST_SOH: begin
				cmd.split_soh = 1'b1;
				state_d       = ST_MIN;
			end
			ST_MIN: begin
				cmd.split_min = 1'b1;
				state_d       = ST_SEC;
			end
			ST_SEC: begin
				cmd.split_sec = 1'b1;
				state_d       = ST_FIN;
			end
			ST_FIN: begin
				if (cal_q == CAL_DONE && out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		case (cal_q)
			CAL_IDLE: ;
			CAL_YEAR: begin
				if (sts.year_fits) cal_d = CAL_MONTH;
				else cmd.year_step = 1'b1;
			end
			CAL_MONTH: begin
				if (sts.month_last) cal_d = CAL_DONE;
				else cmd.month_step = 1'b1;
			end
			CAL_DONE: begin
				if (cmd.out_load) cal_d = CAL_IDLE;
			end
			default: cal_d = CAL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cal_q   <= CAL_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cal_q   <= cal_d;
			// hold the result until taken, refill on the same edge
			if (cmd.out_load) valid_q <= 1'b1;
			else if (date_ready) valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/epoch_seconds_to_calendar_date.sv -----
// Converts a count of seconds since 1970-01-01 00:00:00 UTC into year, month,
// day, hour, minute and second in the fixed UTC+8 zone, one item at a time.
// After a beat is accepted, the zoned time is split into whole days and the
// second of day by reciprocal multiplication, one step per cycle; then the
// year walker subtracts one year length per cycle and the month walker one
// month length per cycle, while hour, minute and second are split off in
// four more steps. The time to a result grows with Y, the number of whole years
// since 1970 (0..68), and with M, the month index (0..11); the year walk is
// its largest part near the top of the range. The input is ready again on
// the cycle after the result is loaded. The result sits in an output
// register, so the next beat is taken as soon as the result is loaded, even
// if it is not yet taken; a later result waits in its last step until then.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date
// Top level: joins the controller and the datapath to the two channels.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date (
	input logic       clk,
	input logic       arst_n,
	ecal_in_if.sink   epoch,
	ecal_out_if.source date
);
	import ecal_pkg::*;

	ecal_cmd_t cmd;
	ecal_sts_t sts;

	ecal_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.epoch_valid (epoch.valid),
		.epoch_ready (epoch.ready),
		.date_valid  (date.valid),
		.date_ready  (date.ready),
		.cmd         (cmd),
		.sts         (sts)
	);

	ecal_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.epoch_data (epoch.data),
		.cmd        (cmd),
		.sts        (sts),
		.date_data  (date.data)
	);

endmodule

// ----- test/ecal_date_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_date_checker
// Watches the epoch and date channels of the converter. Each accepted epoch
// beat is turned into the UTC+8 calendar date it should produce. Each
// accepted date beat is compared field by field against the oldest pending
// date. The package ahead of the module holds the calendar arithmetic.
// ----------------------------------------------------------------------------
package ecal_tb_pkg;
	import ecal_pkg::*;

	localparam longint UtcShift      = 28800;
	localparam longint SecsPerDay    = 86400;
	localparam longint EpochTop      = 2147483647;
	localparam int     FirstYear     = 1970;
	localparam int     YearPassLimit = 69;

	function automatic bit leap_year(int unsigned yr);
		return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
	endfunction

	// month index counts from zero, as the package codes do
	function automatic int unsigned month_days(int unsigned mon, bit leap);
		case (mon)
			MonFeb: return leap ? 29 : 28;
			MonApr, MonJun, MonSep, MonNov: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic ecal_out_t calendar_of(logic [30:0] secs);
		longint      zoned;
		int unsigned days_left;
		int unsigned yr;
		int unsigned mon;
		int unsigned span;
		ecal_out_t   cal;
		zoned = longint'(secs) + UtcShift;
		cal.second = 6'(zoned % 60);
		cal.minute = 6'((zoned / 60) % 60);
		cal.hour   = 5'((zoned / 3600) % 24);
		days_left  = int'(zoned / SecsPerDay);
		yr = FirstYear;
		for (int pass = 0; pass < YearPassLimit; pass++) begin
			span = leap_year(yr) ? 366 : 365;
			if (days_left < span)
				break;
			days_left -= span;
			yr++;
		end
		mon = MonJan;
		while (mon < MonDec) begin
			span = month_days(mon, leap_year(yr));
			if (days_left < span)
				break;
			days_left -= span;
			mon++;
		end
		cal.year  = 11'(yr);
		cal.month = 4'(mon + 1);
		cal.day   = 5'(days_left + 1);
		return cal;
	endfunction

	// seconds since the epoch for a UTC+8 wall-clock time, month from 1
	function automatic longint seconds_of(int yr, int mon, int day, int hr, int mn, int sc);
		longint total;
		total = 0;
		for (int y = FirstYear; y < yr; y++)
			total += leap_year(y) ? 366 : 365;
		for (int m = 0; m < mon - 1; m++)
			total += month_days(m, leap_year(yr));
		total += day - 1;
		return total * SecsPerDay + hr * 3600 + mn * 60 + sc - UtcShift;
	endfunction

	function automatic logic [30:0] to_epoch(longint secs);
		if (secs < 0)
			return '0;
		if (secs > EpochTop)
			return '1;
		return secs[30:0];
	endfunction

endpackage

module ecal_date_checker (
	input logic  clk,
	input logic  arst_n,
	ecal_in_if   epoch,
	ecal_out_if  date,
	output int   mismatches,
	output int   pending
);
	import ecal_pkg::*;
	import ecal_tb_pkg::*;

	ecal_out_t due_dates[$];
	ecal_out_t want;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (epoch.valid && epoch.ready)
				due_dates.push_back(calendar_of(epoch.data.epoch_seconds));
			if (date.valid && date.ready) begin
				if (due_dates.size() == 0) begin
					$error("date beat with no epoch beat pending");
					mismatches++;
				end else begin
					want = due_dates.pop_front();
					check_field("year", want.year, date.data.year);
					check_field("month", want.month, date.data.month);
					check_field("day", want.day, date.data.day);
					check_field("hour", want.hour, date.data.hour);
					check_field("minute", want.minute, date.data.minute);
					check_field("second", want.second, date.data.second);
				end
			end
			pending <= due_dates.size();
		end
	end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives epoch-seconds beats into the converter: calendar edge cases first,
// then random times, many of them close to month and year boundaries. Both
// channel sides idle at random. The checker flags wrong dates; this module
// gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import ecal_tb_pkg::*;

	localparam int RandomBeats = 700;
	localparam int TailCycles  = 150;
	localparam int CycleLimit  = 1000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   mismatches;
	int   pending;
	int   sent = 0;
	int   taken = 0;
	int   cycles = 0;

	ecal_in_if  epoch_ch ();
	ecal_out_if date_ch ();

	epoch_seconds_to_calendar_date DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.epoch  (epoch_ch),
		.date   (date_ch)
	);

	ecal_date_checker date_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.epoch      (epoch_ch),
		.date       (date_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("tb failed");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after the beat
	task automatic send_epoch(logic [30:0] secs);
		int gap;
		gap = (sent % 120 < 25) ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			epoch_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		epoch_ch.valid = 1'b1;
		epoch_ch.data.epoch_seconds = secs;
		do @(posedge clk); while (!(epoch_ch.valid && epoch_ch.ready));
		@(negedge clk);
		sent++;
	endtask

	// result side: stall a random number of cycles before each beat
	initial begin
		int stall;
		date_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = (taken % 150 < 30) ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				date_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			date_ch.ready = 1'b1;
			do @(posedge clk); while (!(date_ch.valid && date_ch.ready));
			@(negedge clk);
			taken++;
		end
	end

	initial begin
		int unsigned kind;
		int          yr;
		int          mon;
		longint      near;
		epoch_ch.valid = 1'b0;
		epoch_ch.data = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_epoch('0);
		send_epoch('1);
		send_epoch(to_epoch(seconds_of(1970, 1, 1, 23, 59, 59)));
		send_epoch(to_epoch(seconds_of(1970, 1, 2, 0, 0, 0)));
		send_epoch(to_epoch(seconds_of(1970, 12, 31, 23, 59, 59)));
		send_epoch(to_epoch(seconds_of(1971, 1, 1, 0, 0, 0)));
		send_epoch(to_epoch(seconds_of(1972, 2, 28, 23, 59, 59)));
		send_epoch(to_epoch(seconds_of(1972, 2, 29, 0, 0, 0)));
		send_epoch(to_epoch(seconds_of(1972, 3, 1, 0, 0, 0)));
		send_epoch(to_epoch(seconds_of(1973, 3, 1, 0, 0, 0) - 1));
		send_epoch(to_epoch(seconds_of(1999, 12, 31, 23, 59, 59)));
		send_epoch(to_epoch(seconds_of(2000, 2, 29, 12, 0, 0)));
		send_epoch(to_epoch(seconds_of(2000, 12, 31, 23, 59, 59)));
		// last second of each month from December 2022 to November 2023
		for (int m = 1; m <= 12; m++)
			send_epoch(to_epoch(seconds_of(2023, m, 1, 0, 0, 0) - 1));

		repeat (RandomBeats) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) begin
				send_epoch(31'($urandom_range(0, 32'h7FFF_FFFF)));
			end else if (kind < 9) begin
				// land within a day either side of a month start
				yr = $urandom_range(1970, 2037);
				mon = $urandom_range(1, 12);
				near = seconds_of(yr, mon, 1, 0, 0, 0)
					+ longint'($urandom_range(0, 172800)) - SecsPerDay;
				send_epoch(to_epoch(near));
			end else begin
				send_epoch(to_epoch(EpochTop - longint'($urandom_range(0, 40000000))));
			end
		end
		epoch_ch.valid = 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/ecal_pkg.sv
src/ecal_in_if.sv
src/ecal_out_if.sv
src/ecal_dp.sv
src/ecal_ctrl.sv
src/epoch_seconds_to_calendar_date.sv
test/ecal_date_checker.sv
test/tb.sv
